// ===== rtl/uas_pkg.sv =====
// Shared constants and types for the unsorted array set unit.
package uas_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ELEM_W   = 32;
  localparam int OUT_CNT_W = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_SCAN    = 6'b000010,
    S_DECIDE  = 6'b000100,
    S_MOVE_RD = 6'b001000,
    S_MOVE_WR = 6'b010000,
    S_RESP    = 6'b100000
  } state_t;

endpackage

// ===== rtl/unsorted_array_set_unit.sv =====
// Set of signed 32-bit values in an unsorted slot memory, searched linearly.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------
//  in_     | input     | in_valid / in_ready  | in_opcode[1:0], in_element[31:0]
//  out_    | output    | out_valid / out_ready| out_was_present, out_full_reject,
//          |           |                      | out_count[6:0]
//
// Steps: a transaction scans the used entries (used = values held), stopping early
//   on a hit, then decides and responds; a delete that hits adds a read of the last
//   entry, then a write into the vacated slot. The single read port of the slot
//   memory reads one entry per cycle during the scan.
// Reset: rst_n low clears the sequencer, the used count and the output valid;
//   the slot memory is not cleared, as only slots below the count are ever read.
// Stalls: a new transaction is taken as soon as the sequencer is idle, even while
//   a result waits in the output register; the finished result then holds in the
//   response state until the output register is free.
module unsorted_array_set_unit
  import uas_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               in_opcode,
  input  logic signed [ELEM_W-1:0] in_element,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_was_present,
  output logic                     out_full_reject,
  output logic [OUT_CNT_W-1:0]     out_count
);

  // Slot memory: one write port, one registered read port.
  logic [ELEM_W-1:0] mem [CAPACITY];
  logic [ELEM_W-1:0] mem_q_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [ELEM_W-1:0] mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [CNT_W-1:0]  issue_idx_r, issue_idx_nxt;   // next slot to read during the scan
  logic [IDX_W-1:0]  pend_idx_r, pend_idx_nxt;     // slot whose data sits in mem_q_r
  logic              pend_r, pend_nxt;             // mem_q_r holds a scan read
  logic              found_r, found_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              reject_r, reject_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [ELEM_W-1:0] elem_r, elem_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic                 out_was_present_r, out_was_present_nxt;
  logic                 out_full_reject_r, out_full_reject_nxt;
  logic [OUT_CNT_W-1:0] out_count_r, out_count_nxt;

  logic in_acc;
  logic out_free;
  logic hit;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  // Compare the entry read in the previous cycle against the search value.
  assign hit      = pend_r && (mem_q_r == elem_r);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q_r <= mem[mem_raddr];
    end
  end

  // Sequencer. Accesses to the memory never overlap between transactions:
  // every write completes before the sequencer returns to idle, so no
  // forwarding is needed.
  always_comb begin
    state_nxt           = state_r;
    used_nxt            = used_r;
    issue_idx_nxt       = issue_idx_r;
    pend_idx_nxt        = pend_idx_r;
    pend_nxt            = 1'b0;
    found_nxt           = found_r;
    pos_nxt             = pos_r;
    reject_nxt          = reject_r;
    op_nxt              = op_r;
    elem_nxt            = elem_r;
    out_valid_nxt       = out_valid_r && !out_ready;
    out_was_present_nxt = out_was_present_r;
    out_full_reject_nxt = out_full_reject_r;
    out_count_nxt       = out_count_r;
    mem_we              = 1'b0;
    mem_waddr           = issue_idx_r[IDX_W-1:0];
    mem_wdata           = elem_r;
    mem_re              = 1'b0;
    mem_raddr           = issue_idx_r[IDX_W-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt        = in_opcode;
          elem_nxt      = in_element;
          issue_idx_nxt = '0;
          found_nxt     = 1'b0;
          reject_nxt    = 1'b0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (hit) begin
          found_nxt = 1'b1;
          pos_nxt   = pend_idx_r;
          state_nxt = S_DECIDE;
        end else if (issue_idx_r == used_r) begin
          state_nxt = S_DECIDE;
        end else begin
          // Issue the read of the next used slot.
          mem_re        = 1'b1;
          mem_raddr     = issue_idx_r[IDX_W-1:0];
          pend_nxt      = 1'b1;
          pend_idx_nxt  = issue_idx_r[IDX_W-1:0];
          issue_idx_nxt = issue_idx_r + CNT_W'(1);
        end
      end
      S_DECIDE: begin
        state_nxt = S_RESP;
        if (op_r == OP_INSERT && !found_r) begin
          if (used_r == CNT_W'(CAPACITY)) begin
            reject_nxt = 1'b1;
          end else begin
            // Append at the slot given by the count.
            mem_we    = 1'b1;
            mem_waddr = used_r[IDX_W-1:0];
            mem_wdata = elem_r;
            used_nxt  = used_r + CNT_W'(1);
          end
        end else if (op_r == OP_DELETE && found_r) begin
          state_nxt = S_MOVE_RD;
        end
      end
      S_MOVE_RD: begin
        // Fetch the last used entry to fill the vacated slot.
        mem_re    = 1'b1;
        mem_raddr = IDX_W'(used_r - CNT_W'(1));
        state_nxt = S_MOVE_WR;
      end
      S_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = mem_q_r;
        used_nxt  = used_r - CNT_W'(1);
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_was_present_nxt = found_r;
          out_full_reject_nxt = reject_r;
          out_count_nxt       = OUT_CNT_W'(used_r);
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issue_idx_r       <= issue_idx_nxt;
    pend_idx_r        <= pend_idx_nxt;
    found_r           <= found_nxt;
    pos_r             <= pos_nxt;
    reject_r          <= reject_nxt;
    op_r              <= op_nxt;
    elem_r            <= elem_nxt;
    out_was_present_r <= out_was_present_nxt;
    out_full_reject_r <= out_full_reject_nxt;
    out_count_r       <= out_count_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_was_present = out_was_present_r;
  assign out_full_reject = out_full_reject_r;
  assign out_count       = out_count_r;

`ifndef SYNTH
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_W'(CAPACITY))
    else $error("used count above capacity");

  a_reject_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_full_reject_r && out_was_present_r))
    else $error("full reject reported for a present value");

  a_used_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DECIDE && state_r != S_MOVE_WR) |=> $stable(used_r))
    else $error("used count changed outside an update state");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_SCAN && issue_idx_r == '0))
    else $error("accepted transaction did not start a scan");
`endif

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the unsorted array set unit: directed and random set operations.
`timescale 1ns / 100ps

module tb
  import uas_pkg::*;
();

  // One queued operation and one predicted response.
  typedef struct {
    logic [1:0]               op;
    logic signed [ELEM_W-1:0] val;
  } set_req_t;

  typedef struct {
    logic                 was_present;
    logic                 full_reject;
    logic [OUT_CNT_W-1:0] count;
  } set_resp_t;

  localparam int POOL_SZ   = 72;   // more values than slots, so grow rounds hit the full store
  localparam int RAND_ITEMS = 600;
  localparam int DRAIN_CYCLES = 80; // longest operation is a full scan plus a move

  logic                     clk        = 1'b0;
  logic                     rst_n      = 1'b0;
  logic                     in_valid   = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_opcode  = OP_QUERY;
  logic signed [ELEM_W-1:0] in_element = '0;
  logic                     out_valid;
  logic                     out_ready  = 1'b0;
  logic                     out_was_present;
  logic                     out_full_reject;
  logic [OUT_CNT_W-1:0]     out_count;

  // Predictor state: a private copy of the slot store and its fill count.
  logic signed [ELEM_W-1:0] set_slots [CAPACITY];
  int                       set_used = 0;

  set_req_t  req_pending [$];
  set_resp_t resp_expected [$];

  int  mismatches   = 0;
  int  in_taken     = 0;
  int  out_checked  = 0;
  int  rejects_pred = 0;
  int  del_hits     = 0;
  int  ins_hits     = 0;
  int  gap_left     = 0;
  int  stall_left   = 0;
  logic in_fire;
  logic long_hold   = 1'b0;

  // A window in which neither side idles.
  wire calm = (in_taken >= 300) && (in_taken < 400);

  unsorted_array_set_unit u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_element      (in_element),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_was_present (out_was_present),
    .out_full_reject (out_full_reject),
    .out_count       (out_count)
  );

  always #5 clk = ~clk;

  // Apply one operation to the predicted set and queue the response it must produce.
  task automatic apply_set_op(input logic [1:0] op, input logic signed [ELEM_W-1:0] v);
    int        pos;
    set_resp_t r;
    pos = -1;
    for (int i = 0; i < set_used; i++) begin
      if (pos < 0 && set_slots[i] == v) pos = i;
    end
    r.was_present = (pos >= 0);
    r.full_reject = 1'b0;
    if (op == OP_INSERT) begin
      if (pos < 0) begin
        if (set_used >= CAPACITY) begin
          r.full_reject = 1'b1;
          rejects_pred++;
        end else begin
          set_slots[set_used] = v;
          set_used++;
        end
      end else begin
        ins_hits++;
      end
    end else if (op == OP_DELETE) begin
      // Fill the hole with the last used entry, then shrink.
      if (pos >= 0) begin
        set_slots[pos] = set_slots[set_used - 1];
        set_used--;
        del_hits++;
      end
    end
    // OP_QUERY and the unused code change nothing.
    r.count = set_used[OUT_CNT_W-1:0];
    resp_expected.push_back(r);
  endtask

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic queue_op(input logic [1:0] op, input logic signed [ELEM_W-1:0] v);
    set_req_t q;
    q.op  = op;
    q.val = v;
    req_pending.push_back(q);
  endtask

  // Idle lengths: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(10, 40);
  endfunction

  // Random value, now and then one of the edge values.
  function automatic logic signed [ELEM_W-1:0] pick_val();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return 32'sh8000_0000;
    if (r < 4) return 32'sh7FFF_FFFF;
    if (r < 6) return -32'sd1;
    if (r < 8) return 32'sd0;
    return $urandom;
  endfunction

  function automatic logic [1:0] pick_mixed_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return OP_INSERT;
    if (r < 65) return OP_DELETE;
    if (r < 95) return OP_QUERY;
    return 2'b11;
  endfunction

  // Driver: offer the pending operations, predict each one as its transaction is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) begin
        apply_set_op(in_opcode, in_element);
        in_taken++;
        gap_left = calm ? 0 : pick_gap();
      end
      if (!in_valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_pending.size() > 0) begin
          in_valid   <= 1'b1;
          in_opcode  <= req_pending[0].op;
          in_element <= req_pending[0].val;
          void'(req_pending.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall at random, not at all in the calm window, and throughout the long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else begin
      stall_left = pick_gap();
      out_ready <= (stall_left == 0);
    end
  end

  // Monitor: check each response against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (resp_expected.size() == 0) begin
        flag_mismatch($sformatf("response with nothing expected (count %0d)", out_count));
      end else begin
        if (out_was_present !== resp_expected[0].was_present)
          flag_mismatch($sformatf("result %0d was_present got %b want %b", out_checked,
                                  out_was_present, resp_expected[0].was_present));
        if (out_full_reject !== resp_expected[0].full_reject)
          flag_mismatch($sformatf("result %0d full_reject got %b want %b", out_checked,
                                  out_full_reject, resp_expected[0].full_reject));
        if (out_count !== resp_expected[0].count)
          flag_mismatch($sformatf("result %0d count got %0d want %0d", out_checked,
                                  out_count, resp_expected[0].count));
        void'(resp_expected.pop_front());
      end
      out_checked++;
    end
  end

  // Hold the receiver off for a long stretch so the unit backs up and stalls its input.
  initial begin
    while (in_taken < 150) @(posedge clk);
    long_hold <= 1'b1;
    repeat (1500) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Stimulus and end of run.
  initial begin
    logic signed [ELEM_W-1:0] val_pool [POOL_SZ];
    logic signed [ELEM_W-1:0] tmp;
    int rnd_made;
    int round;
    int j;
    int n_queued;

    // Directed: edge values, present and absent cases, the unused code, empty store.
    queue_op(OP_INSERT, 32'sh8000_0000);
    queue_op(OP_INSERT, 32'sh7FFF_FFFF);
    queue_op(OP_INSERT, 32'sh8000_0000);   // already present
    queue_op(OP_QUERY,  32'sh7FFF_FFFF);
    queue_op(OP_QUERY,  32'sd0);           // absent
    queue_op(OP_INSERT, 32'sd0);
    queue_op(OP_INSERT, -32'sd1);
    queue_op(2'b11,     -32'sd1);          // unused code acts as a query
    queue_op(2'b11,     32'sd12345);
    queue_op(OP_DELETE, 32'sd12345);       // absent, ignored
    queue_op(OP_DELETE, 32'sh8000_0000);   // last entry moves into slot 0
    queue_op(OP_QUERY,  32'sh8000_0000);
    queue_op(OP_QUERY,  -32'sd1);
    queue_op(OP_DELETE, -32'sd1);
    queue_op(OP_DELETE, 32'sh7FFF_FFFF);
    queue_op(OP_DELETE, 32'sd0);           // store now empty
    queue_op(OP_DELETE, 32'sd0);
    queue_op(OP_QUERY,  32'sd0);
    queue_op(OP_INSERT, 32'sh5555_5555);
    queue_op(OP_INSERT, 32'shAAAA_AAAA);
    queue_op(OP_DELETE, 32'sh5555_5555);
    queue_op(OP_QUERY,  32'shAAAA_AAAA);

    // Random rounds: grow past full, mix, shrink towards empty, mix again.
    rnd_made = 0;
    round = 0;
    for (int k = 0; k < POOL_SZ; k++) val_pool[k] = pick_val();
    while (rnd_made < RAND_ITEMS) begin
      case (round % 4)
        0: begin
          for (int k = 0; k < POOL_SZ; k++) begin
            if ($urandom_range(0, 3) == 0) val_pool[k] = pick_val();
          end
          for (int k = 0; k < POOL_SZ; k++) begin
            queue_op(OP_INSERT, val_pool[k]);
            rnd_made++;
            if ($urandom_range(0, 3) == 0) begin
              queue_op(pick_mixed_op(), val_pool[$urandom_range(0, POOL_SZ - 1)]);
              rnd_made++;
            end
          end
        end
        2: begin
          // Shuffle so deletes land on every slot position.
          for (int k = POOL_SZ - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            tmp = val_pool[k];
            val_pool[k] = val_pool[j];
            val_pool[j] = tmp;
          end
          for (int k = 0; k < POOL_SZ; k++) begin
            queue_op(OP_DELETE, val_pool[k]);
            rnd_made++;
            if ($urandom_range(0, 4) == 0) begin
              queue_op(OP_QUERY, val_pool[$urandom_range(0, POOL_SZ - 1)]);
              rnd_made++;
            end
          end
        end
        default: begin
          for (int k = 0; k < 60; k++) begin
            if ($urandom_range(0, 99) < 85)
              queue_op(pick_mixed_op(), val_pool[$urandom_range(0, POOL_SZ - 1)]);
            else
              queue_op(pick_mixed_op(), pick_val());
            rnd_made++;
          end
        end
      endcase
      round++;
    end
    n_queued = req_pending.size();

    // Reset once, then let the driver run.
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every transaction to be taken and every response to arrive.
    while (in_taken < n_queued || resp_expected.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d operations, %0d responses checked.", in_taken, out_checked);
    $display("Full-store rejects %0d, delete hits %0d, repeat inserts %0d.",
             rejects_pred, del_hits, ins_hits);
    if (mismatches == 0 && resp_expected.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Timed out with %0d responses outstanding.", resp_expected.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
